// File: hw/rtl/fsnp_pkg.sv
// Shared types and constants for the FAT short name parser.
`default_nettype none

package fsnp_pkg;

  localparam int unsigned BaseLen = 8;
  localparam int unsigned ExtLen  = 3;
  localparam int unsigned BaseW   = BaseLen * 8;
  localparam int unsigned ExtW    = ExtLen * 8;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CaseDelta = 8'h20;

  localparam logic [3:0] BaseMax = 4'd8;
  localparam logic [1:0] ExtMax  = 2'd3;

  // Byte classification handed from the decoder to the name builder.
  typedef struct packed {
    logic       term;   // zero byte, ends the name
    logic       slash;
    logic       dot;
    logic       bad;    // control, space or forbidden punctuation
    logic [7:0] ch;     // upper-cased byte
  } cls_t;

endpackage

`default_nettype wire

// File: hw/rtl/fsnp_classify.sv
// Byte decoder: upper-casing and character class flags.
`default_nettype none

module fsnp_classify (
  input  wire logic [7:0]   char_i,
  output fsnp_pkg::cls_t    cls_o
);

  logic [7:0] up;
  logic       punct;

  always_comb begin
    if (char_i >= fsnp_pkg::CharLowA && char_i <= fsnp_pkg::CharLowZ) begin
      up = char_i - fsnp_pkg::CaseDelta;
    end else begin
      up = char_i;
    end
  end

  // FAT-forbidden punctuation: " * + , : ; < = > ? [ \ ] |
  always_comb begin
    case (up)
      8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h3A, 8'h3B, 8'h3C,
      8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: punct = 1'b1;
      default: punct = 1'b0;
    endcase
  end

  always_comb begin
    cls_o.term  = (char_i == 8'h00);
    cls_o.slash = (up == fsnp_pkg::CharSlash);
    cls_o.dot   = (up == fsnp_pkg::CharDot);
    cls_o.bad   = (up <= fsnp_pkg::CharSpace) || punct;
    cls_o.ch    = up;
  end

endmodule

`default_nettype wire

// File: hw/rtl/fsnp_name_acc.sv
// Name builder: base/extension buffers, counters and reject tracking.
`default_nettype none

module fsnp_name_acc (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      take_i,
  input  wire fsnp_pkg::cls_t            cls_i,
  output logic [fsnp_pkg::BaseW-1:0]     base_o,
  output logic [fsnp_pkg::ExtW-1:0]      ext_o,
  output logic                           ok_o
);

  logic [fsnp_pkg::BaseW-1:0] base_q, base_d;
  logic [fsnp_pkg::ExtW-1:0]  ext_q, ext_d;
  logic [3:0] base_cnt_q, base_cnt_d;
  logic [1:0] ext_cnt_q, ext_cnt_d;
  logic       in_ext_q, in_ext_d;
  logic       rej_q, rej_d;
  logic       first_q, first_d;

  assign ok_o   = !rej_q && (base_cnt_q != 4'd0) && !(in_ext_q && ext_cnt_q == 2'd0);
  assign base_o = ok_o ? base_q : '0;
  assign ext_o  = ok_o ? ext_q  : '0;

  always_comb begin
    base_d     = base_q;
    ext_d      = ext_q;
    base_cnt_d = base_cnt_q;
    ext_cnt_d  = ext_cnt_q;
    in_ext_d   = in_ext_q;
    rej_d      = rej_q;
    first_d    = first_q;
    if (take_i) begin
      if (cls_i.term) begin
        base_d     = {fsnp_pkg::BaseLen{fsnp_pkg::CharSpace}};
        ext_d      = {fsnp_pkg::ExtLen{fsnp_pkg::CharSpace}};
        base_cnt_d = 4'd0;
        ext_cnt_d  = 2'd0;
        in_ext_d   = 1'b0;
        rej_d      = 1'b0;
        first_d    = 1'b1;
      end else begin
        first_d = 1'b0;
        if (!rej_q) begin
          if (cls_i.slash) begin
            if (!first_q) begin
              rej_d = 1'b1;
            end
          end else if (cls_i.dot) begin
            if (in_ext_q || base_cnt_q == 4'd0) begin
              rej_d = 1'b1;
            end else begin
              in_ext_d = 1'b1;
            end
          end else if (cls_i.bad) begin
            rej_d = 1'b1;
          end else if (!in_ext_q) begin
            if (base_cnt_q >= fsnp_pkg::BaseMax) begin
              rej_d = 1'b1;
            end else begin
              for (int i = 0; i < fsnp_pkg::BaseLen; i++) begin
                if (base_cnt_q[2:0] == 3'(i)) begin
                  base_d[i*8 +: 8] = cls_i.ch;
                end
              end
              base_cnt_d = base_cnt_q + 4'd1;
            end
          end else begin
            if (ext_cnt_q >= fsnp_pkg::ExtMax) begin
              rej_d = 1'b1;
            end else begin
              for (int i = 0; i < fsnp_pkg::ExtLen; i++) begin
                if (ext_cnt_q == 2'(i)) begin
                  ext_d[i*8 +: 8] = cls_i.ch;
                end
              end
              ext_cnt_d = ext_cnt_q + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= {fsnp_pkg::BaseLen{fsnp_pkg::CharSpace}};
      ext_q      <= {fsnp_pkg::ExtLen{fsnp_pkg::CharSpace}};
      base_cnt_q <= 4'd0;
      ext_cnt_q  <= 2'd0;
      in_ext_q   <= 1'b0;
      rej_q      <= 1'b0;
      first_q    <= 1'b1;
    end else begin
      base_q     <= base_d;
      ext_q      <= ext_d;
      base_cnt_q <= base_cnt_d;
      ext_cnt_q  <= ext_cnt_d;
      in_ext_q   <= in_ext_d;
      rej_q      <= rej_d;
      first_q    <= first_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fat_short_name_parser.sv
// Top level of the FAT 8.3 short name parser.
// Usage:
//  - Input channel: one name byte per word on char_code_i (in_valid_i /
//    in_stall_o). A zero byte ends the name.
//  - Output channel: one word per name (out_valid_o / out_stall_i) with the
//    space-padded base (name_base_o, first char in the low byte), extension
//    (name_ext_o) and name_ok_o. Base and extension read zero when the name
//    is rejected.
//  - Path: a terminating zero byte passes through the input register, then
//    the result register, on its way to the outputs.
//  - Throughput: one byte per cycle. Nonzero bytes never wait on the output
//    side; a zero byte waits in the input register only while a previous
//    result is held by out_stall_i, and in_stall_o then rises.
//  - Reset (rst_ni low, asynchronous): both registers empty, name state
//    cleared to spaces and zero counts, ready for a new name.
//  - Stall: a held result stays stable on the outputs until taken.
`default_nettype none

module fat_short_name_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    char_code_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [fsnp_pkg::BaseW-1:0]         name_base_o,
  output logic [fsnp_pkg::ExtW-1:0]          name_ext_o,
  output logic                               name_ok_o
);

  // Input register
  logic       in_vld_q;
  logic [7:0] char_q;

  fsnp_pkg::cls_t cls;
  logic           s1_move;
  logic           take;

  logic [fsnp_pkg::BaseW-1:0] res_base;
  logic [fsnp_pkg::ExtW-1:0]  res_ext;
  logic                       res_ok;

  // Result register
  logic                       out_vld_q;
  logic [fsnp_pkg::BaseW-1:0] base_q;
  logic [fsnp_pkg::ExtW-1:0]  ext_q;
  logic                       ok_q;

  fsnp_classify u_classify (
    .char_i (char_q),
    .cls_o  (cls)
  );

  // Held byte leaves stage one unless it needs the result register and
  // that register is full and stalled.
  assign s1_move   = !cls.term || !out_vld_q || !out_stall_i;
  assign take      = in_vld_q && s1_move;
  assign in_stall_o = in_vld_q && !s1_move;

  fsnp_name_acc u_name_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .cls_i  (cls),
    .base_o (res_base),
    .ext_o  (res_ext),
    .ok_o   (res_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take && cls.term) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cls.term) begin
      base_q <= res_base;
      ext_q  <= res_ext;
      ok_q   <= res_ok;
    end
  end

  assign out_valid_o = out_vld_q;
  assign name_base_o = base_q;
  assign name_ext_o  = ext_q;
  assign name_ok_o   = ok_q;

endmodule

`default_nettype wire
